@@ hw/rtl/pfba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame bitmap allocator package
// Shared widths, row geometry, action codes and status codes.
// ----------------------------------------------------------------------------
package pfba_pkg;

    // Byte address and page number geometry.
    localparam int ADDR_W     = 24;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
    // A page limit can equal the full page count, so it takes one more bit.
    localparam int LIM_W      = PAGE_NUM_W + 1;

    // One memory row holds the map bits of 64 pages (eight map bytes).
    localparam int ROW_PAGES  = 64;
    localparam int ROW_SHIFT  = 6;
    localparam int BYTE_PAGES = 8;

    // Configuration register.
    localparam int                 MAP_BYTES_W     = 10;
    localparam [MAP_BYTES_W-1:0]   MAP_BYTES_RESET = 10'd512;

    // Action codes.
    localparam int           ACTION_W      = 3;
    localparam [ACTION_W-1:0] ACT_ALLOC     = 3'd0;
    localparam [ACTION_W-1:0] ACT_FREE      = 3'd1;
    localparam [ACTION_W-1:0] ACT_MARK_FREE = 3'd2;
    localparam [ACTION_W-1:0] ACT_MARK_USED = 3'd3;
    localparam [ACTION_W-1:0] ACT_QUERY     = 3'd4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

endpackage
`default_nettype wire

@@ hw/rtl/pfba_map_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame bitmap memory
// One-port-read, one-port-write synchronous row memory with per-row valid
// bits; a row that was never written reads as all pages used.
// ----------------------------------------------------------------------------
module pfba_map_mem #(
    parameter int ROWS  = 64,
    parameter int ROW_W = 6
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_rd_en,
    input  wire logic [ROW_W-1:0]               i_rd_row,
    output logic      [pfba_pkg::ROW_PAGES-1:0] o_rd_data,
    input  wire logic                           i_wr_en,
    input  wire logic [ROW_W-1:0]               i_wr_row,
    input  wire logic [pfba_pkg::ROW_PAGES-1:0] i_wr_data
);

    logic [pfba_pkg::ROW_PAGES-1:0] r_mem [ROWS];
    logic [pfba_pkg::ROW_PAGES-1:0] r_rd_data;
    logic [ROWS-1:0]                r_valid;
    logic                           r_rd_valid;

    // Data array: no reset, contents only matter once the row is valid.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    // Valid bits are cleared by reset, which makes the whole map read as used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
`default_nettype wire

@@ hw/rtl/page_frame_bitmap_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame bitmap allocator, first fit
// Keeps one bit per 4 KiB page frame (1 = free) in a row memory and serves
// allocate, free, mark-free, mark-used and query commands one at a time.
// ----------------------------------------------------------------------------
//
//  Channel    Signals                                    Transfer when
//  ---------  -----------------------------------------  ------------------------
//  command    start, busy, i_action, i_address           start high, busy low
//  result     o_done, o_page_address, o_page_free,       o_done high (one cycle)
//             o_status
//  config     i_cfg_we, i_cfg_data (map_bytes)           i_cfg_we high
//
// Sequence: a single-page command holds busy in S_MOD (one row read, then
// the modify and write back); its result strobes on the cycle after S_MOD.
// A command that is out of range, an unknown action or an allocate on an
// empty map shows its result on the cycle after the transfer and never
// raises busy. Allocate reads one 64-page row per cycle through the map
// memory's single read port and holds busy while it scans, up to
// ceil(min(map_bytes, 512) / 8) rows (64 with the default map).
// Reset: the per-row valid bits clear in the reset cycle, so the whole map
// reads as used at once; there is no clearing pass. map_bytes resets to 512.
// The receiver cannot stall: every result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_top #(
    parameter int PAGE_COUNT = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Command transfer.
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [pfba_pkg::ACTION_W-1:0]       i_action,
    input  wire logic [pfba_pkg::ADDR_W-1:0]         i_address,
    // Result transfer.
    output logic                                     o_done,
    output logic      [pfba_pkg::ADDR_W-1:0]         o_page_address,
    output logic                                     o_page_free,
    output logic      [1:0]                          o_status,
    // Configuration write.
    input  wire logic                                i_cfg_we,
    input  wire logic [pfba_pkg::MAP_BYTES_W-1:0]    i_cfg_data
);

    // Pages reachable through a 24-bit address; anything above this can never
    // be freed, so it is not stored.
    localparam int ADDR_PAGES   = 1 << pfba_pkg::PAGE_NUM_W;
    localparam int STORED_PAGES = (PAGE_COUNT < ADDR_PAGES) ? PAGE_COUNT : ADDR_PAGES;
    localparam int STORED_BYTES = (STORED_PAGES + pfba_pkg::BYTE_PAGES - 1)
                                  / pfba_pkg::BYTE_PAGES;
    // Largest page limit an allocate scan can use, byte aligned.
    localparam int LIM_MAX      = STORED_BYTES * pfba_pkg::BYTE_PAGES;
    localparam int ROWS         = (LIM_MAX + pfba_pkg::ROW_PAGES - 1) / pfba_pkg::ROW_PAGES;
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam [pfba_pkg::LIM_W-1:0] LIM_MAX_V      = pfba_pkg::LIM_W'(LIM_MAX);
    localparam [pfba_pkg::LIM_W-1:0] STORED_PAGES_V = pfba_pkg::LIM_W'(STORED_PAGES);
    localparam [pfba_pkg::LIM_W-1:0] ROW_PAGES_V    = pfba_pkg::LIM_W'(pfba_pkg::ROW_PAGES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOD
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                              r_state,  n_state;
    logic [pfba_pkg::ACTION_W-1:0]       r_action, n_action;
    logic [pfba_pkg::PAGE_NUM_W-1:0]     r_page,   n_page;
    logic [ROW_W-1:0]                    r_row,    n_row;
    logic [ROW_W-1:0]                    r_last,   n_last;
    logic [pfba_pkg::LIM_W-1:0]          r_lim,    n_lim;
    logic                                r_done,   n_done;
    logic [pfba_pkg::ADDR_W-1:0]         r_page_address, n_page_address;
    logic                                r_page_free,    n_page_free;
    pfba_pkg::t_status                   r_status,       n_status;
    logic [pfba_pkg::MAP_BYTES_W-1:0]    r_map_bytes;

    // ------------------------------------------------------------------
    // Map memory
    // ------------------------------------------------------------------
    logic                                mem_rd_en;
    logic [ROW_W-1:0]                    mem_rd_row;
    logic [pfba_pkg::ROW_PAGES-1:0]      mem_rd_data;
    logic                                mem_wr_en;
    logic [pfba_pkg::ROW_PAGES-1:0]      mem_wr_data;

    pfba_map_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_map_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_row  (mem_rd_row),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_row  (r_row),
        .i_wr_data (mem_wr_data)
    );

    // ------------------------------------------------------------------
    // Command decode at the transfer
    // ------------------------------------------------------------------
    logic [pfba_pkg::PAGE_NUM_W-1:0]     in_page;
    logic [pfba_pkg::LIM_W-1:0]          cfg_lim;
    logic [pfba_pkg::LIM_W-1:0]          scan_lim;
    logic                                in_range;

    assign in_page  = i_address[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT];
    // map_bytes * 8 pages; a length past the stored map saturates.
    assign cfg_lim  = {r_map_bytes, 3'b000};
    assign scan_lim = (cfg_lim > LIM_MAX_V) ? LIM_MAX_V : cfg_lim;
    assign in_range = ({1'b0, in_page} < cfg_lim) && ({1'b0, in_page} < STORED_PAGES_V);

    // ------------------------------------------------------------------
    // Scan datapath: mask off pages past the limit, then find the lowest
    // free page, first by byte and then by bit within that byte.
    // ------------------------------------------------------------------
    logic [pfba_pkg::LIM_W-1:0]          row_base;
    logic [pfba_pkg::LIM_W-1:0]          row_rem;
    logic [pfba_pkg::ROW_PAGES-1:0]      row_mask;
    logic [pfba_pkg::ROW_PAGES-1:0]      row_free;
    logic [7:0]                          byte_nz;
    logic [2:0]                          sel_byte;
    logic [7:0]                          sel_bits;
    logic [2:0]                          sel_bit;
    logic [pfba_pkg::ROW_SHIFT-1:0]      hit_ix;
    logic [pfba_pkg::PAGE_NUM_W-1:0]     hit_page;

    assign row_base = pfba_pkg::LIM_W'({r_row, 6'b000000});
    assign row_rem  = r_lim - row_base;
    assign row_mask = (row_rem >= ROW_PAGES_V) ? '1
                    : ((64'd1 << row_rem[pfba_pkg::ROW_SHIFT-1:0]) - 64'd1);
    assign row_free = mem_rd_data & row_mask;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            byte_nz[b] = |row_free[b*8 +: 8];
        end
    end

    always_comb begin
        sel_byte = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (byte_nz[b]) begin
                sel_byte = 3'(b);
            end
        end
    end

    assign sel_bits = row_free[{sel_byte, 3'b000} +: 8];

    always_comb begin
        sel_bit = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (sel_bits[i]) begin
                sel_bit = 3'(i);
            end
        end
    end

    assign hit_ix   = {sel_byte, sel_bit};
    assign hit_page = pfba_pkg::PAGE_NUM_W'(row_base) | pfba_pkg::PAGE_NUM_W'(hit_ix);

    // ------------------------------------------------------------------
    // Single-page datapath
    // ------------------------------------------------------------------
    logic [pfba_pkg::ROW_PAGES-1:0]      page_mask;
    logic                                page_bit;

    assign page_mask = 64'd1 << r_page[pfba_pkg::ROW_SHIFT-1:0];
    assign page_bit  = |(mem_rd_data & page_mask);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_action       = r_action;
        n_page         = r_page;
        n_row          = r_row;
        n_last         = r_last;
        n_lim          = r_lim;
        n_done         = 1'b0;
        n_page_address = '0;
        n_page_free    = 1'b0;
        n_status       = pfba_pkg::ST_OK;
        mem_rd_en      = 1'b0;
        mem_rd_row     = r_row;
        mem_wr_en      = 1'b0;
        mem_wr_data    = mem_rd_data;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action = i_action;
                    n_page   = in_page;
                    n_lim    = scan_lim;
                    n_last   = ROW_W'((scan_lim - 1'b1) >> pfba_pkg::ROW_SHIFT);
                    if (i_action == pfba_pkg::ACT_ALLOC) begin
                        if (scan_lim == '0) begin
                            n_done   = 1'b1;
                            n_status = pfba_pkg::ST_NOFREE;
                        end else begin
                            // Row 0 is read now; its data is checked in S_SCAN.
                            n_row      = '0;
                            mem_rd_en  = 1'b1;
                            mem_rd_row = '0;
                            n_state    = S_SCAN;
                        end
                    end else if ((i_action == pfba_pkg::ACT_FREE
                               || i_action == pfba_pkg::ACT_MARK_FREE
                               || i_action == pfba_pkg::ACT_MARK_USED
                               || i_action == pfba_pkg::ACT_QUERY) && in_range) begin
                        n_row      = ROW_W'(in_page >> pfba_pkg::ROW_SHIFT);
                        mem_rd_en  = 1'b1;
                        mem_rd_row = ROW_W'(in_page >> pfba_pkg::ROW_SHIFT);
                        n_state    = S_MOD;
                    end else begin
                        n_done   = 1'b1;
                        n_status = pfba_pkg::ST_RANGE;
                    end
                end
            end

            S_SCAN: begin
                if (byte_nz != 8'd0) begin
                    // Claim the page and write the row back.
                    mem_wr_en      = 1'b1;
                    mem_wr_data    = mem_rd_data & ~(64'd1 << hit_ix);
                    n_done         = 1'b1;
                    n_page_address = {hit_page, {pfba_pkg::PAGE_SHIFT{1'b0}}};
                    n_state        = S_IDLE;
                end else if (r_row == r_last) begin
                    n_done   = 1'b1;
                    n_status = pfba_pkg::ST_NOFREE;
                    n_state  = S_IDLE;
                end else begin
                    // Fetch the next row while this one is being checked.
                    mem_rd_en  = 1'b1;
                    mem_rd_row = ROW_W'(r_row + 1'b1);
                    n_row      = ROW_W'(r_row + 1'b1);
                end
            end

            S_MOD: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                case (r_action)
                    pfba_pkg::ACT_FREE: begin
                        if (page_bit) begin
                            n_status = pfba_pkg::ST_DOUBLE;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = mem_rd_data | page_mask;
                        end
                    end
                    pfba_pkg::ACT_MARK_FREE: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data | page_mask;
                    end
                    pfba_pkg::ACT_MARK_USED: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data & ~page_mask;
                    end
                    pfba_pkg::ACT_QUERY: begin
                        n_page_free = page_bit;
                    end
                    default: begin
                        n_status = pfba_pkg::ST_RANGE;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_map_bytes <= pfba_pkg::MAP_BYTES_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_map_bytes <= i_cfg_data;
            end
        end
        r_action       <= n_action;
        r_page         <= n_page;
        r_row          <= n_row;
        r_last         <= n_last;
        r_lim          <= n_lim;
        r_page_address <= n_page_address;
        r_page_free    <= n_page_free;
        r_status       <= n_status;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_page_address = r_page_address;
    assign o_page_free    = r_page_free;
    assign o_status       = r_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every accepted command either reports on the next cycle or is in work.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted command neither reported nor started work");

    // The scan never runs past the last row of the configured map.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_row <= r_last))
        else $error("allocate scan ran past the last map row");

    // A failed command never returns a page address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != pfba_pkg::ST_OK)) |-> (o_page_address == '0))
        else $error("failed command returned a page address");

    // A free page is only reported by a successful query.
    a_free_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_page_free) |-> (o_status == pfba_pkg::ST_OK))
        else $error("page_free set on a failed command");

    // The map is only written while a command is in work.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> (r_state == S_SCAN || r_state == S_MOD))
        else $error("map memory written while idle");

endmodule
`default_nettype wire

@@ sim/page_frame_bitmap_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame bitmap allocator testbench
// Drives allocate, free, mark and query commands through the start/busy
// port and checks every result strobe against a behavioral scoreboard of the
// free map and the map_bytes register, across several map lengths and
// sender idle rates.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_top_tb;

    // Number of map bytes the block holds (4096 pages, eight per byte).
    localparam int MAP_DEPTH  = 512;
    localparam int ACTION_MAX = (1 << pfba_pkg::ACTION_W) - 1;

    typedef struct packed {
        logic [pfba_pkg::ACTION_W-1:0] action;
        logic [pfba_pkg::ADDR_W-1:0]   address;
    } t_command;

    typedef struct packed {
        logic [pfba_pkg::ADDR_W-1:0] page_address;
        logic                        page_free;
        pfba_pkg::t_status           status;
    } t_frame_result;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             start      = 1'b0;
    logic [pfba_pkg::ACTION_W-1:0]    i_action   = '0;
    logic [pfba_pkg::ADDR_W-1:0]      i_address  = '0;
    logic                             i_cfg_we   = 1'b0;
    logic [pfba_pkg::MAP_BYTES_W-1:0] i_cfg_data = '0;
    logic                             busy;
    logic                             o_done;
    logic [pfba_pkg::ADDR_W-1:0]      o_page_address;
    logic                             o_page_free;
    logic [1:0]                       o_status;

    // Commands waiting for the driver, and results the block still owes us.
    t_command      pending_cmds[$];
    t_frame_result awaited_results[$];

    // Scoreboard copy of the block's state.
    logic [7:0]                       free_bytes [0:MAP_DEPTH-1];
    logic [pfba_pkg::MAP_BYTES_W-1:0] map_len_cfg;

    int mismatch_count = 0;
    int idle_pct       = 0;
    bit cmd_accepted   = 1'b0;

    page_frame_bitmap_allocator_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_address      (i_address),
        .o_done         (o_done),
        .o_page_address (o_page_address),
        .o_page_free    (o_page_free),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out what one accepted command does to the free map and what the
    // block must answer. Allocation is first fit: the lowest nonzero byte
    // below the active length, then its lowest set bit.
    task automatic apply_command(input logic [pfba_pkg::ACTION_W-1:0] action,
                                 input logic [pfba_pkg::ADDR_W-1:0] address,
                                 output t_frame_result res);
        logic [pfba_pkg::PAGE_NUM_W-1:0] page;
        int                              active;
        int                              byte_ix;
        int                              b;
        int                              i;
        int                              low;
        int                              addr_int;
        logic                            found;
        logic [2:0]                      bit_ix;
        res.page_address = '0;
        res.page_free    = 1'b0;
        res.status       = pfba_pkg::ST_OK;
        page    = address[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT];
        byte_ix = int'(page >> 3);
        bit_ix  = page[2:0];
        // A register value past the end of the map saturates to the full map.
        active  = (map_len_cfg > MAP_DEPTH) ? MAP_DEPTH : int'(map_len_cfg);
        if (action == pfba_pkg::ACT_ALLOC) begin
            res.status = pfba_pkg::ST_NOFREE;
            found = 1'b0;
            for (b = 0; b < active && !found; b++) begin
                if (free_bytes[b] != 8'h00) begin
                    found = 1'b1;
                    low = 0;
                    for (i = 7; i >= 0; i--) begin
                        if (free_bytes[b][i]) low = i;
                    end
                    free_bytes[b][low] = 1'b0;
                    addr_int = (b * pfba_pkg::BYTE_PAGES + low) << pfba_pkg::PAGE_SHIFT;
                    res.page_address = addr_int[pfba_pkg::ADDR_W-1:0];
                    res.status = pfba_pkg::ST_OK;
                end
            end
        end else if (action > pfba_pkg::ACT_QUERY) begin
            res.status = pfba_pkg::ST_RANGE;
        end else if (page >= active * pfba_pkg::BYTE_PAGES) begin
            res.status = pfba_pkg::ST_RANGE;
        end else begin
            case (action)
                pfba_pkg::ACT_FREE: begin
                    if (free_bytes[byte_ix][bit_ix]) res.status = pfba_pkg::ST_DOUBLE;
                    else free_bytes[byte_ix][bit_ix] = 1'b1;
                end
                pfba_pkg::ACT_MARK_FREE: free_bytes[byte_ix][bit_ix] = 1'b1;
                pfba_pkg::ACT_MARK_USED: free_bytes[byte_ix][bit_ix] = 1'b0;
                default:                 res.page_free = free_bytes[byte_ix][bit_ix];
            endcase
        end
    endtask

    // Driver: presents commands at the falling edge. A command stays on the
    // port until the rising edge that takes it; after that the next command
    // goes out, or start drops for an idle cycle at the phase's idle rate.
    always @(negedge i_clk) begin
        t_command    next_cmd;
        logic [31:0] rnd;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !cmd_accepted) begin
            // Still waiting for the block to take the current command.
        end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            next_cmd  = pending_cmds.pop_front();
            start     <= 1'b1;
            i_action  <= next_cmd.action;
            i_address <= next_cmd.address;
        end else begin
            // Idle cycle: the command fields carry noise that must be ignored.
            rnd       = $urandom;
            start     <= 1'b0;
            i_action  <= rnd[pfba_pkg::ACTION_W-1:0];
            i_address <= rnd[31:32-pfba_pkg::ADDR_W];
        end
    end

    // Monitor and scoreboard at the rising edge. The result check runs first,
    // since a result strobe always belongs to a command taken earlier.
    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result got;
        int            k;
        cmd_accepted = i_rst_n && start && !busy;
        if (!i_rst_n) begin
            for (k = 0; k < MAP_DEPTH; k++) free_bytes[k] = 8'h00;
            map_len_cfg = pfba_pkg::MAP_BYTES_RESET;
        end else begin
            if (o_done) begin
                got.page_address = o_page_address;
                got.page_free    = o_page_free;
                got.status       = pfba_pkg::t_status'(o_status);
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing outstanding: addr %h free %0d status %0d",
                             $time, got.page_address, got.page_free, got.status);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.page_address !== want.page_address) begin
                        $display("%0t: page_address expected %h actual %h",
                                 $time, want.page_address, got.page_address);
                        mismatch_count++;
                    end
                    if (got.page_free !== want.page_free) begin
                        $display("%0t: page_free expected %0d actual %0d",
                                 $time, want.page_free, got.page_free);
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) map_len_cfg = i_cfg_data;
            if (cmd_accepted) begin
                apply_command(i_action, i_address, want);
                awaited_results.push_back(want);
            end
        end
    end

    function automatic void queue_cmd(input logic [pfba_pkg::ACTION_W-1:0] action,
                                      input logic [pfba_pkg::ADDR_W-1:0] address);
        t_command c;
        c.action  = action;
        c.address = address;
        pending_cmds.push_back(c);
    endfunction

    // Blocks until every queued command has been taken and answered.
    task automatic wait_for_drain();
        while (pending_cmds.size() != 0 || start || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // The register is only rewritten while the block is idle.
    task automatic write_map_bytes(input logic [pfba_pkg::MAP_BYTES_W-1:0] value);
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random traffic for one phase. The map starts mostly used, so each phase
    // with a nonempty map opens with a run of mark-free commands near its
    // bottom; after that allocations mix with frees, marks and queries. Most
    // addresses fall inside the active map, and the low pages, where first fit
    // allocates, get extra weight so that frees often hit allocated pages.
    task automatic queue_random_cmds(input int count, input int map_len);
        int                            limit;
        int                            low_span;
        int                            n;
        int                            pick;
        int                            page;
        logic [31:0]                   rnd;
        logic [pfba_pkg::ADDR_W-1:0]   addr;
        logic [pfba_pkg::ACTION_W-1:0] action;
        limit    = ((map_len > MAP_DEPTH) ? MAP_DEPTH : map_len) * pfba_pkg::BYTE_PAGES;
        low_span = (limit < 128) ? limit : 128;
        if (limit > 0) begin
            for (n = 0; n < 10; n++) begin
                rnd  = $urandom;
                page = $urandom_range(0, low_span - 1);
                addr = {page[pfba_pkg::PAGE_NUM_W-1:0], rnd[pfba_pkg::PAGE_SHIFT-1:0]};
                queue_cmd(pfba_pkg::ACT_MARK_FREE, addr);
            end
        end
        for (n = 0; n < count; n++) begin
            rnd  = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 28)      action = pfba_pkg::ACT_ALLOC;
            else if (pick < 43) action = pfba_pkg::ACT_FREE;
            else if (pick < 68) action = pfba_pkg::ACT_MARK_FREE;
            else if (pick < 78) action = pfba_pkg::ACT_MARK_USED;
            else if (pick < 94) action = pfba_pkg::ACT_QUERY;
            else action = pfba_pkg::ACTION_W'($urandom_range(pfba_pkg::ACT_QUERY + 1,
                                                             ACTION_MAX));
            pick = $urandom_range(0, 19);
            if (limit > 0 && pick < 8)
                page = $urandom_range(0, low_span - 1);
            else if (limit > 0 && pick < 16)
                page = $urandom_range(0, limit - 1);
            else if (limit > 0 && pick < 18)
                // Just inside, or just past, the end of the active map.
                page = (limit < 4096 && pick == 17) ? limit : limit - 1;
            else
                page = $urandom_range(0, 4095);
            addr = {page[pfba_pkg::PAGE_NUM_W-1:0], rnd[pfba_pkg::PAGE_SHIFT-1:0]};
            queue_cmd(action, addr);
        end
    endtask

    // Main sequence: reset, a directed pass over the corner cases, then
    // random phases with different map lengths and sender idle rates.
    initial begin
        int          ph;
        int          map_len;
        logic [31:0] rnd;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Full map after reset: everything starts out used.
        queue_cmd(pfba_pkg::ACT_ALLOC,     24'h000000);
        queue_cmd(pfba_pkg::ACT_QUERY,     24'h000000);
        queue_cmd(pfba_pkg::ACT_MARK_FREE, 24'h000ABC);
        queue_cmd(pfba_pkg::ACT_QUERY,     24'h000FFF);
        // Page zero comes back as address 0 with an ok status.
        queue_cmd(pfba_pkg::ACT_ALLOC,     24'h000000);
        queue_cmd(pfba_pkg::ACT_FREE,      24'h000123);
        queue_cmd(pfba_pkg::ACT_FREE,      24'h000000);
        queue_cmd(pfba_pkg::ACT_MARK_USED, 24'h000000);
        queue_cmd(pfba_pkg::ACT_MARK_FREE, 24'hFFFFFF);
        queue_cmd(pfba_pkg::ACT_QUERY,     24'hFFF000);
        // Only the last page is free, so this scan walks the whole map.
        queue_cmd(pfba_pkg::ACT_ALLOC,     24'hFFFFFF);
        queue_cmd(pfba_pkg::ACT_ALLOC,     24'h000000);
        // Action codes past query are rejected as out of range.
        queue_cmd(pfba_pkg::ACTION_W'(pfba_pkg::ACT_QUERY + 1), 24'hABCDEF);
        queue_cmd(pfba_pkg::ACTION_W'(pfba_pkg::ACT_QUERY + 2), 24'h543210);
        queue_cmd(pfba_pkg::ACTION_W'(ACTION_MAX),              24'hFFFFFF);

        // Two map bytes: pages 16 and up lie outside the map.
        write_map_bytes(10'd2);
        queue_cmd(pfba_pkg::ACT_MARK_FREE, 24'h00F000);
        queue_cmd(pfba_pkg::ACT_QUERY,     24'h010000);
        queue_cmd(pfba_pkg::ACT_FREE,      24'h010000);
        queue_cmd(pfba_pkg::ACT_MARK_USED, 24'hFFFFFF);
        queue_cmd(pfba_pkg::ACT_ALLOC,     24'h000000);

        // Empty map: nothing to allocate and every page is out of range.
        write_map_bytes(10'd0);
        queue_cmd(pfba_pkg::ACT_ALLOC,     24'h000000);
        queue_cmd(pfba_pkg::ACT_QUERY,     24'h000000);

        // An oversized length saturates to the full map.
        write_map_bytes(10'd1023);
        queue_cmd(pfba_pkg::ACT_MARK_FREE, 24'hFFF000);
        queue_cmd(pfba_pkg::ACT_QUERY,     24'hFFFFFF);
        queue_cmd(pfba_pkg::ACT_MARK_USED, 24'hFFF000);

        for (ph = 0; ph < 8; ph++) begin
            rnd = $urandom;
            case (ph)
                0: begin map_len = 512;  idle_pct = 0;  end
                1: begin map_len = 1023; idle_pct = 75; end
                2: begin map_len = 8;    idle_pct = 0;  end
                3: begin map_len = 0;    idle_pct = 33; end
                4: begin map_len = 513;  idle_pct = 75; end
                5: begin map_len = 1;    idle_pct = 33; end
                6: begin map_len = 64;   idle_pct = 75; end
                default: begin
                    map_len  = int'(rnd[pfba_pkg::MAP_BYTES_W-1:0]);
                    idle_pct = 0;
                end
            endcase
            write_map_bytes(map_len[pfba_pkg::MAP_BYTES_W-1:0]);
            queue_random_cmds(84, map_len);
        end

        wait_for_drain();
        // Allow for a stray late strobe before calling the run.
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("page_frame_bitmap_allocator_top test passed");
        end else begin
            $display("page_frame_bitmap_allocator_top test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of full-map scans.
    initial begin
        #(5_000_000);
        $display("page_frame_bitmap_allocator_top test failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pfba_pkg.sv
hw/rtl/pfba_map_mem.sv
hw/rtl/page_frame_bitmap_allocator_top.sv
sim/page_frame_bitmap_allocator_top_tb.sv
